// ===== hdl/union_find_engine_core_defines.svh =====
// ----------------------------------------------------------------------------
// Union-find engine assertion macros
// Concurrent assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef UNION_FIND_ENGINE_CORE_DEFINES_SVH
`define UNION_FIND_ENGINE_CORE_DEFINES_SVH

// assertion that is quiet while reset is applied
`define UFE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion that also holds through reset
`define UFE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/ufe_pkg.sv =====
// ----------------------------------------------------------------------------
// Union-find engine package
// Table sizes, request and result word types, sequencer states.
// ----------------------------------------------------------------------------
package ufe_pkg;

    localparam int NODES  = 1024;
    localparam int IDX_W  = $clog2(NODES);
    localparam int CNT_W  = IDX_W + 1;
    localparam int SIZE_W = CNT_W;

    typedef enum logic {
        REQ_QUERY = 1'b0,
        REQ_MERGE = 1'b1
    } t_req_type;

    typedef struct packed {
        logic             req_type;
        logic [IDX_W-1:0] node_a;
        logic [IDX_W-1:0] node_b;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0]  root_a;
        logic [IDX_W-1:0]  root_b;
        logic              same_set;
        logic              merged;
        logic [SIZE_W-1:0] set_size;
        logic              bad_index;
    } t_res;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND_RD,
        S_FIND_CHK,
        S_CMP_RD,
        S_CMP_CHK,
        S_SZ_RDB,
        S_SZ_RDA,
        S_SZ_CHK,
        S_PUSH
    } t_state;

endpackage

// ===== hdl/union_find_engine_core.sv =====
// Sequencing: a rejected request goes straight to the push state once accepted; a valid one
// resolves each node in turn by a find walk to its root, then a compression pass over the
// same path, and a merge that joins two sets also reads the size of the second root.
// Throughput: one request at a time; o_in_ready rises the cycle after the word is loaded, and
// a word stalled at the output holds the sequencer in its final state.
// Reset: synchronous, active low; a clearing pass over all NODES (1024) entries rebuilds both tables.
// ----------------------------------------------------------------------------
// Union-find engine core
// Disjoint-set table with full path compression, driven by a small sequencer
// over one parent memory and one set-size memory.
// ----------------------------------------------------------------------------
module union_find_engine_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  ufe_pkg::t_req               i_req,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output ufe_pkg::t_res               o_res,
    input  logic                        i_cfg_we,
    input  logic [ufe_pkg::CNT_W-1:0]   i_cfg_data
);

    localparam int IW = ufe_pkg::IDX_W;
    localparam int SW = ufe_pkg::SIZE_W;

    ufe_pkg::t_state r_state, n_state;

    logic [IW-1:0] r_parent_mem [ufe_pkg::NODES];
    logic [SW-1:0] r_size_mem   [ufe_pkg::NODES];
    logic [IW-1:0] r_p_rd;
    logic [SW-1:0] r_s_rd;

    logic          p_we;
    logic [IW-1:0] p_wa, p_wd, p_ra;
    logic          s_we;
    logic [IW-1:0] s_wa, s_ra;
    logic [SW-1:0] s_wd;

    logic [ufe_pkg::CNT_W-1:0] r_node_count;
    logic [IW-1:0] r_clr;
    logic          r_merge;
    logic          r_bad;
    logic          r_side;
    logic [IW-1:0] r_b, r_cur, r_start, r_root, r_ra, r_rb;
    logic [SW-1:0] r_szb, r_size;
    logic          r_join;
    logic          r_out_valid;
    ufe_pkg::t_res r_res;

    logic          accept;
    logic          bad_in;
    logic          do_join;
    logic          push;
    logic [SW-1:0] size_sum;

    assign accept   = i_in_valid && o_in_ready;
    assign bad_in   = ({1'b0, i_req.node_a} >= r_node_count) ||
                      ({1'b0, i_req.node_b} >= r_node_count);
    assign do_join  = (r_merge == ufe_pkg::REQ_MERGE) && (r_ra != r_rb);
    assign push     = (r_state == ufe_pkg::S_PUSH) && (!r_out_valid || i_out_ready);
    assign size_sum = r_s_rd + r_szb;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ufe_pkg::S_CLEAR: begin
                if (r_clr == '1) n_state = ufe_pkg::S_IDLE;
            end
            ufe_pkg::S_IDLE: begin
                if (accept) n_state = bad_in ? ufe_pkg::S_PUSH : ufe_pkg::S_FIND_RD;
            end
            ufe_pkg::S_FIND_RD: n_state = ufe_pkg::S_FIND_CHK;
            ufe_pkg::S_FIND_CHK: begin
                if (r_p_rd == r_cur) n_state = ufe_pkg::S_CMP_RD;
            end
            ufe_pkg::S_CMP_RD: begin
                if (r_cur != r_root)  n_state = ufe_pkg::S_CMP_CHK;
                else if (!r_side)     n_state = ufe_pkg::S_FIND_RD;
                else if (r_merge == ufe_pkg::REQ_MERGE && r_ra != r_root)
                                      n_state = ufe_pkg::S_SZ_RDB;
                else                  n_state = ufe_pkg::S_SZ_RDA;
            end
            ufe_pkg::S_CMP_CHK: begin
                if (r_p_rd == r_root) n_state = ufe_pkg::S_CMP_RD;
            end
            ufe_pkg::S_SZ_RDB: n_state = ufe_pkg::S_SZ_RDA;
            ufe_pkg::S_SZ_RDA: n_state = ufe_pkg::S_SZ_CHK;
            ufe_pkg::S_SZ_CHK: n_state = ufe_pkg::S_PUSH;
            ufe_pkg::S_PUSH: begin
                if (push) n_state = ufe_pkg::S_IDLE;
            end
            default: n_state = ufe_pkg::S_CLEAR;
        endcase
    end

    // memory controls and handshake
    always_comb begin
        o_in_ready = 1'b0;
        p_we = 1'b0;
        p_wa = r_cur;
        p_wd = r_root;
        p_ra = r_cur;
        s_we = 1'b0;
        s_wa = r_ra;
        s_wd = size_sum;
        s_ra = r_ra;
        case (r_state)
            ufe_pkg::S_CLEAR: begin
                p_we = 1'b1;
                p_wa = r_clr;
                p_wd = r_clr;
                s_we = 1'b1;
                s_wa = r_clr;
                s_wd = SW'(1);
            end
            ufe_pkg::S_IDLE: o_in_ready = 1'b1;
            ufe_pkg::S_FIND_CHK: begin
                p_ra = r_p_rd;
            end
            ufe_pkg::S_CMP_CHK: begin
                p_we = 1'b1;
                p_ra = r_p_rd;
            end
            ufe_pkg::S_SZ_RDB: s_ra = r_rb;
            ufe_pkg::S_SZ_CHK: begin
                if (do_join) begin
                    s_we = 1'b1;
                    p_we = 1'b1;
                    p_wa = r_rb;
                    p_wd = r_ra;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (p_we) r_parent_mem[p_wa] <= p_wd;
        r_p_rd <= r_parent_mem[p_ra];
        if (s_we) r_size_mem[s_wa] <= s_wd;
        r_s_rd <= r_size_mem[s_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ufe_pkg::S_CLEAR;
            r_clr        <= '0;
            r_node_count <= ufe_pkg::CNT_W'(ufe_pkg::NODES);
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_node_count <= i_cfg_data;
            if (r_state == ufe_pkg::S_CLEAR) r_clr <= r_clr + IW'(1);
            if (push) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ufe_pkg::S_IDLE: begin
                r_merge <= i_req.req_type;
                r_b     <= i_req.node_b;
                r_cur   <= i_req.node_a;
                r_start <= i_req.node_a;
                r_bad   <= bad_in;
                r_side  <= 1'b0;
                r_join  <= 1'b0;
            end
            ufe_pkg::S_FIND_CHK: begin
                if (r_p_rd == r_cur) begin
                    r_root <= r_cur;
                    r_cur  <= r_start;
                end else begin
                    r_cur  <= r_p_rd;
                end
            end
            ufe_pkg::S_CMP_RD: begin
                if (r_cur == r_root) begin
                    if (!r_side) begin
                        r_ra    <= r_root;
                        r_side  <= 1'b1;
                        r_cur   <= r_b;
                        r_start <= r_b;
                    end else begin
                        r_rb <= r_root;
                    end
                end
            end
            ufe_pkg::S_CMP_CHK: r_cur <= r_p_rd;
            ufe_pkg::S_SZ_RDA: r_szb <= r_s_rd;
            ufe_pkg::S_SZ_CHK: begin
                r_join <= do_join;
                r_size <= do_join ? size_sum : r_s_rd;
            end
            default: ;
        endcase
        if (push) begin
            r_res.bad_index <= r_bad;
            r_res.root_a    <= r_bad ? '0 : r_ra;
            r_res.root_b    <= r_bad ? '0 : r_rb;
            r_res.same_set  <= !r_bad && (r_ra == r_rb);
            r_res.merged    <= !r_bad && r_join;
            r_res.set_size  <= r_bad ? '0 : r_size;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

endmodule

// ===== hdl/ufe_checker.sv =====
// ----------------------------------------------------------------------------
// Union-find engine port checker
// Port-level assertions on the core, attached by bind.
// ----------------------------------------------------------------------------
`include "union_find_engine_core_defines.svh"

module ufe_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input ufe_pkg::t_res               o_res
);

    `UFE_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_res), "result word dropped or changed while stalled")
    `UFE_ASSERT(a_bad_zero, i_clk, i_rst_n, o_out_valid && o_res.bad_index |-> o_res.root_a == '0 && o_res.root_b == '0 && o_res.set_size == '0 && !o_res.merged && !o_res.same_set, "rejected word carries data")
    `UFE_ASSERT(a_merge_excl, i_clk, i_rst_n, o_out_valid && o_res.merged |-> !o_res.same_set && o_res.set_size > 1, "merged word with same set or size one")
    `UFE_ASSERT(a_same_root, i_clk, i_rst_n, o_out_valid && o_res.same_set |-> o_res.root_a == o_res.root_b && o_res.set_size != '0, "same set with different roots")
    `UFE_ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !o_in_ready && !o_out_valid, "ready during clearing pass")

endmodule

bind union_find_engine_core ufe_checker u_ufe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_res       (o_res)
);
